// File: design/momentum_displacement_dedup_table_core_assert.svh
// Assertion macros for the dedup table core
`ifndef MOMENTUM_DISPLACEMENT_DEDUP_TABLE_CORE_ASSERT_SVH
`define MOMENTUM_DISPLACEMENT_DEDUP_TABLE_CORE_ASSERT_SVH

// same-cycle implication
`define MDDT_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define MDDT_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// File: design/mddt_pkg.sv
package mddt_pkg;

  localparam int TABLE_DEPTH_DEF = 256;
  localparam int FW              = 4;
  localparam int KW              = 6 * FW;
  localparam int OUT_IDX_W       = 8;

  localparam logic signed [FW-1:0] FIELD_MIN = 4'sb1000;

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_SCAN = 1'b1;

  typedef struct packed {
    logic signed [FW-1:0] mom_x;
    logic signed [FW-1:0] mom_y;
    logic signed [FW-1:0] mom_z;
    logic signed [FW-1:0] disp_x;
    logic signed [FW-1:0] disp_y;
    logic signed [FW-1:0] disp_z;
  } key_t;

  typedef struct packed {
    logic hit;
    logic dagger;
  } match_t;

endpackage

// File: design/mddt_match.sv
module mddt_match (
  input  mddt_pkg::key_t   probe,
  input  mddt_pkg::key_t   stored,
  output mddt_pkg::match_t result
);

  logic signed [mddt_pkg::FW-1:0] neg_x;
  logic signed [mddt_pkg::FW-1:0] neg_y;
  logic signed [mddt_pkg::FW-1:0] neg_z;
  logic disp_zero;
  logic same_disp;
  logic same_mom;
  logic neg_mom;

  assign neg_x = -probe.mom_x;
  assign neg_y = -probe.mom_y;
  assign neg_z = -probe.mom_z;

  assign disp_zero = (probe.disp_x == '0) && (probe.disp_y == '0) && (probe.disp_z == '0);
  assign same_disp = (stored.disp_x == probe.disp_x) && (stored.disp_y == probe.disp_y) &&
                     (stored.disp_z == probe.disp_z);
  assign same_mom  = (stored.mom_x == probe.mom_x) && (stored.mom_y == probe.mom_y) &&
                     (stored.mom_z == probe.mom_z);
  assign neg_mom   = (stored.mom_x == neg_x) && (probe.mom_x != mddt_pkg::FIELD_MIN) &&
                     (stored.mom_y == neg_y) && (probe.mom_y != mddt_pkg::FIELD_MIN) &&
                     (stored.mom_z == neg_z) && (probe.mom_z != mddt_pkg::FIELD_MIN);

  assign result.hit    = same_disp && (same_mom || (neg_mom && disp_zero));
  assign result.dagger = !same_mom;

endmodule

// File: design/momentum_displacement_dedup_table_core.sv
// Channel   Ports                              Transaction
// input     start, busy, in_*                  start high while busy low
// result    out_valid, out_*                   out_valid high for one cycle
//
// An item with N stored entries scans at most N of them: one key memory read
// per cycle, the read data registered, compared, and the decision registered.
// An item that finds an empty table is answered in the cycle after acceptance.
// A hit ends the scan early. busy spans a scan, from acceptance to result.
// Reset clears the entry count; key memory contents are not cleared.
// The result cannot be stalled.
`include "momentum_displacement_dedup_table_core_assert.svh"

module momentum_displacement_dedup_table_core #(
  parameter int TABLE_DEPTH = mddt_pkg::TABLE_DEPTH_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            start,
  output logic                            busy,
  input  logic signed [mddt_pkg::FW-1:0]  in_momentum_x,
  input  logic signed [mddt_pkg::FW-1:0]  in_momentum_y,
  input  logic signed [mddt_pkg::FW-1:0]  in_momentum_z,
  input  logic signed [mddt_pkg::FW-1:0]  in_displacement_x,
  input  logic signed [mddt_pkg::FW-1:0]  in_displacement_y,
  input  logic signed [mddt_pkg::FW-1:0]  in_displacement_z,
  output logic                            out_valid,
  output logic [mddt_pkg::OUT_IDX_W-1:0]  out_entry_index,
  output logic                            out_needs_dagger,
  output logic                            out_newly_added,
  output logic                            out_table_full
);

  localparam int AW = $clog2(TABLE_DEPTH);
  localparam int CW = $clog2(TABLE_DEPTH + 1);

  logic                     state_r, state_nxt;
  logic [CW-1:0]            count_r, count_nxt;
  mddt_pkg::key_t           key_r, key_nxt;
  logic [AW-1:0]            addr_r, addr_nxt;
  logic                     iss_done_r, iss_done_nxt;
  logic                     chk_vld_r, chk_vld_nxt;
  logic                     chk_last_r, chk_last_nxt;
  logic [AW-1:0]            chk_idx_r, chk_idx_nxt;
  logic                     out_valid_r, out_valid_nxt;
  logic [AW-1:0]            out_idx_r, out_idx_nxt;
  logic                     out_dagger_r, out_dagger_nxt;
  logic                     out_new_r, out_new_nxt;
  logic                     out_full_r, out_full_nxt;

  logic [mddt_pkg::KW-1:0]  key_mem_r [TABLE_DEPTH];
  mddt_pkg::key_t           rd_data_r;
  logic                     mem_we;
  mddt_pkg::key_t           mem_wd;
  mddt_pkg::key_t           in_key;
  mddt_pkg::match_t         match;
  logic                     tbl_full;
  logic [AW+mddt_pkg::OUT_IDX_W-1:0] idx_wide;

  assign in_key.mom_x  = in_momentum_x;
  assign in_key.mom_y  = in_momentum_y;
  assign in_key.mom_z  = in_momentum_z;
  assign in_key.disp_x = in_displacement_x;
  assign in_key.disp_y = in_displacement_y;
  assign in_key.disp_z = in_displacement_z;

  assign tbl_full = (count_r == CW'(TABLE_DEPTH));

  mddt_match u_match (
    .probe  (key_r),
    .stored (rd_data_r),
    .result (match)
  );

  always_ff @(posedge clk) begin
    if (mem_we) begin
      key_mem_r[count_r[AW-1:0]] <= mem_wd;
    end
    rd_data_r <= key_mem_r[addr_r];
  end

  always_comb begin
    state_nxt      = state_r;
    count_nxt      = count_r;
    key_nxt        = key_r;
    addr_nxt       = addr_r;
    iss_done_nxt   = iss_done_r;
    chk_vld_nxt    = 1'b0;
    chk_last_nxt   = chk_last_r;
    chk_idx_nxt    = chk_idx_r;
    out_valid_nxt  = 1'b0;
    out_idx_nxt    = out_idx_r;
    out_dagger_nxt = out_dagger_r;
    out_new_nxt    = out_new_r;
    out_full_nxt   = out_full_r;
    mem_we         = 1'b0;
    mem_wd         = key_r;
    unique case (state_r)
      mddt_pkg::ST_IDLE: begin
        if (start) begin
          key_nxt = in_key;
          if (count_r == '0) begin
            mem_we         = 1'b1;
            mem_wd         = in_key;
            count_nxt      = CW'(1);
            out_valid_nxt  = 1'b1;
            out_idx_nxt    = '0;
            out_dagger_nxt = 1'b0;
            out_new_nxt    = 1'b1;
            out_full_nxt   = 1'b0;
          end else begin
            state_nxt    = mddt_pkg::ST_SCAN;
            addr_nxt     = '0;
            iss_done_nxt = 1'b0;
          end
        end
      end
      mddt_pkg::ST_SCAN: begin
        if (!iss_done_r) begin
          chk_vld_nxt  = 1'b1;
          chk_idx_nxt  = addr_r;
          chk_last_nxt = (CW'(addr_r) + CW'(1) == count_r);
          iss_done_nxt = chk_last_nxt;
          addr_nxt     = addr_r + AW'(1);
        end
        priority if (chk_vld_r && match.hit) begin
          state_nxt      = mddt_pkg::ST_IDLE;
          chk_vld_nxt    = 1'b0;
          out_valid_nxt  = 1'b1;
          out_idx_nxt    = chk_idx_r;
          out_dagger_nxt = match.dagger;
          out_new_nxt    = 1'b0;
          out_full_nxt   = 1'b0;
        end else if (chk_vld_r && chk_last_r) begin
          state_nxt      = mddt_pkg::ST_IDLE;
          chk_vld_nxt    = 1'b0;
          out_valid_nxt  = 1'b1;
          out_dagger_nxt = 1'b0;
          if (tbl_full) begin
            out_idx_nxt  = '0;
            out_new_nxt  = 1'b0;
            out_full_nxt = 1'b1;
          end else begin
            mem_we       = 1'b1;
            count_nxt    = count_r + CW'(1);
            out_idx_nxt  = count_r[AW-1:0];
            out_new_nxt  = 1'b1;
            out_full_nxt = 1'b0;
          end
        end else begin
          state_nxt = mddt_pkg::ST_SCAN;
        end
      end
      default: begin
        state_nxt = mddt_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= mddt_pkg::ST_IDLE;
      count_r     <= '0;
      chk_vld_r   <= 1'b0;
      out_valid_r <= 1'b0;
      iss_done_r  <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      chk_vld_r   <= chk_vld_nxt;
      out_valid_r <= out_valid_nxt;
      iss_done_r  <= iss_done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    key_r        <= key_nxt;
    addr_r       <= addr_nxt;
    chk_last_r   <= chk_last_nxt;
    chk_idx_r    <= chk_idx_nxt;
    out_idx_r    <= out_idx_nxt;
    out_dagger_r <= out_dagger_nxt;
    out_new_r    <= out_new_nxt;
    out_full_r   <= out_full_nxt;
  end

  assign idx_wide         = {{mddt_pkg::OUT_IDX_W{1'b0}}, out_idx_r};
  assign busy             = (state_r != mddt_pkg::ST_IDLE);
  assign out_valid        = out_valid_r;
  assign out_entry_index  = idx_wide[mddt_pkg::OUT_IDX_W-1:0];
  assign out_needs_dagger = out_dagger_r;
  assign out_newly_added  = out_new_r;
  assign out_table_full   = out_full_r;

  `MDDT_ASSERT_NOW(a_result_when_idle, out_valid_r, state_r == mddt_pkg::ST_IDLE, "result while scanning")
  `MDDT_ASSERT_NOW(a_count_bound, 1'b1, count_r <= CW'(TABLE_DEPTH), "entry count past depth")
  `MDDT_ASSERT_NEXT(a_accept_progress, start && !busy, out_valid_r || busy, "accepted item dropped")
  `MDDT_ASSERT_NOW(a_flags_exclusive, out_valid_r && out_full_r, !out_new_r && !out_dagger_r, "full with other flags")

endmodule
